[src/fpps_pkg.sv]
// ----------------------------------------------------------------------------
// fpps_pkg
// Shared constants and control types for the roulette-wheel parent selector.
// ----------------------------------------------------------------------------
package fpps_pkg;

  localparam int POP_MAX          = 64;
  localparam int IDX_BITS         = $clog2(POP_MAX);
  localparam int FIT_BITS         = 32;
  localparam int FRAC_BITS        = 32;
  localparam int POP_BITS         = 7;   // width of the population_size register
  localparam int SUM_BITS         = FIT_BITS + IDX_BITS;
  localparam int SUM_HI_BITS      = SUM_BITS - FRAC_BITS;
  localparam int DRAW_BITS        = 7;
  localparam int MAX_MOTHER_DRAWS = 101;
  localparam int POP_RESET        = 64;

  // request codes on req_type
  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_DRAW = 1'b1;

  // controller -> datapath
  typedef struct packed {
    logic start;     // draw accepted: clear sum pass, latch fraction
    logic load;      // load accepted: write table
    logic sum_run;   // stream table into the total
    logic mul_lo;    // fraction x low word of total
    logic mul_hi;    // add fraction x high bits, arm the scan
    logic scan_run;  // stream table into the cumulative compare
    logic emit;      // push result into the output register
  } fpps_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic beat;      // table word present in the read register
    logic last;      // that word is the last entry of the population
    logic hit;       // cumulative sum passed the threshold
    logic sum_zero;  // total fitness is zero
    logic out_free;  // output register can take a result
  } fpps_sts_t;

endpackage

[src/fitness_proportionate_parent_select.sv]
// ----------------------------------------------------------------------------
// fitness_proportionate_parent_select
// Roulette-wheel parent selection over a 64-entry fitness table.
// ----------------------------------------------------------------------------
// Input channel (in_valid_i / in_stall_o): each transfer is either a load
// (req_type 0) writing fitness_value into slot entry_index, or a draw
// (req_type 1) carrying random_fraction, a uniform fraction times 2^32.
// A load is absorbed from idle and gives no result. A draw gives exactly
// one result transfer on the output channel (out_valid_o / out_stall_i).
// Draw steps, n = clamped population: a pass sums the table through its
// single registered read port, a 32x32 multiply on the low word and a
// 32x6 multiply on the high bits form fraction x total, a second pass
// over up to n entries walks the cumulative sum, and the result loads
// into the output register. The table read port sets both passes.
// Only one draw is in flight; in_stall_o is high from acceptance until the
// result enters the output register, so no new draw is taken before then.
// A stalled output holds the draw in its final state and the input stalls.
// Reset clears the pair state and sets population_size to 64; the table is
// not cleared and must be loaded before draws. cfg_ready_o is always high;
// write population_size only while the block is idle.
// ----------------------------------------------------------------------------
module fitness_proportionate_parent_select (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         req_type_i,
  input  logic [fpps_pkg::IDX_BITS-1:0]  entry_index_i,
  input  logic [fpps_pkg::FIT_BITS-1:0]  fitness_value_i,
  input  logic [fpps_pkg::FRAC_BITS-1:0] random_fraction_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [fpps_pkg::IDX_BITS-1:0]  selected_index_o,
  output logic                         is_mother_o,
  output logic                         pair_done_o,
  output logic                         zero_total_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [fpps_pkg::POP_BITS-1:0]  population_size_i
);
  import fpps_pkg::*;

  fpps_cmd_t cmd;
  fpps_sts_t sts;

  // register writes complete in the cycle they are offered
  assign cfg_ready_o = 1'b1;

  fpps_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .req_type_i (req_type_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  fpps_dp u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .entry_index_i     (entry_index_i),
    .fitness_value_i   (fitness_value_i),
    .random_fraction_i (random_fraction_i),
    .cfg_valid_i       (cfg_valid_i && cfg_ready_o),
    .population_size_i (population_size_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .selected_index_o  (selected_index_o),
    .is_mother_o       (is_mother_o),
    .pair_done_o       (pair_done_o),
    .zero_total_o      (zero_total_o)
  );

endmodule

[src/fpps_ctrl.sv]
// ----------------------------------------------------------------------------
// fpps_ctrl
// Sequencer for one draw: sum pass, two-step multiply, scan, result.
// ----------------------------------------------------------------------------
module fpps_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              req_type_i,
  output logic              in_stall_o,
  input  fpps_pkg::fpps_sts_t sts_i,
  output fpps_pkg::fpps_cmd_t cmd_o
);
  import fpps_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUM,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_SCAN,
    ST_EMIT
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && (state_q == ST_IDLE);

  always_comb begin
    state_d  = state_q;
    cmd_o    = '0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (req_type_i == REQ_DRAW) begin
            cmd_o.start = 1'b1;
            state_d     = ST_SUM;
          end else begin
            cmd_o.load = 1'b1;
          end
        end
      end
      ST_SUM: begin
        cmd_o.sum_run = 1'b1;
        if (sts_i.beat && sts_i.last) begin
          state_d = ST_MUL_LO;
        end
      end
      ST_MUL_LO: begin
        cmd_o.mul_lo = 1'b1;
        state_d      = sts_i.sum_zero ? ST_EMIT : ST_MUL_HI;
      end
      ST_MUL_HI: begin
        cmd_o.mul_hi = 1'b1;
        state_d      = ST_SCAN;
      end
      ST_SCAN: begin
        cmd_o.scan_run = 1'b1;
        if (sts_i.beat && (sts_i.hit || sts_i.last)) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

[src/fpps_dp.sv]
// ----------------------------------------------------------------------------
// fpps_dp
// Fitness table, total and threshold arithmetic, scan, pair state, result reg.
// ----------------------------------------------------------------------------
module fpps_dp (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  fpps_pkg::fpps_cmd_t          cmd_i,
  output fpps_pkg::fpps_sts_t          sts_o,
  input  logic [fpps_pkg::IDX_BITS-1:0]  entry_index_i,
  input  logic [fpps_pkg::FIT_BITS-1:0]  fitness_value_i,
  input  logic [fpps_pkg::FRAC_BITS-1:0] random_fraction_i,
  input  logic                         cfg_valid_i,
  input  logic [fpps_pkg::POP_BITS-1:0]  population_size_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [fpps_pkg::IDX_BITS-1:0]  selected_index_o,
  output logic                         is_mother_o,
  output logic                         pair_done_o,
  output logic                         zero_total_o
);
  import fpps_pkg::*;

  logic [FIT_BITS-1:0]     mem [POP_MAX];

  logic [POP_BITS-1:0]     pop_q;
  logic [IDX_BITS-1:0]     n_m1;

  logic [FRAC_BITS-1:0]    frac_q;
  logic [IDX_BITS-1:0]     addr_q;
  logic                    issue_done_q;
  logic                    rd_en;
  logic                    rdv_q;
  logic [FIT_BITS-1:0]     rd_data_q;
  logic [IDX_BITS-1:0]     rd_idx_q;
  logic                    rd_last_q;

  logic [SUM_BITS-1:0]     sum_q;
  logic [2*FRAC_BITS-1:0]  prod_lo_q;
  logic [SUM_BITS-1:0]     thresh_q;
  logic [SUM_BITS-1:0]     cum_q, cum_d;
  logic [SUM_BITS-1:0]     part_hi;
  logic [IDX_BITS-1:0]     pick_q;
  logic                    zero_q;

  logic                    awaiting_q;
  logic [IDX_BITS-1:0]     father_q;
  logic [DRAW_BITS-1:0]    draws_q, draws_inc;
  logic                    mother_done;

  logic                    out_valid_q;
  logic [IDX_BITS-1:0]     sel_q;
  logic                    mother_q, done_q, zero_out_q;

  // population clamped to [2, POP_MAX], held as last index
  always_comb begin
    if (pop_q < POP_BITS'(2)) begin
      n_m1 = IDX_BITS'(1);
    end else if (pop_q > POP_BITS'(POP_MAX)) begin
      n_m1 = IDX_BITS'(POP_MAX - 1);
    end else begin
      n_m1 = IDX_BITS'(pop_q - POP_BITS'(1));
    end
  end

  assign rd_en   = (cmd_i.sum_run || cmd_i.scan_run) && !issue_done_q;
  assign cum_d   = cum_q + SUM_BITS'(rd_data_q);
  assign part_hi = SUM_BITS'(frac_q * sum_q[SUM_BITS-1:FRAC_BITS]);

  assign draws_inc   = draws_q + DRAW_BITS'(1);
  assign mother_done = (pick_q != father_q) || (draws_inc >= DRAW_BITS'(MAX_MOTHER_DRAWS));

  assign sts_o.beat     = rdv_q;
  assign sts_o.last     = rd_last_q;
  assign sts_o.hit      = (cum_d > thresh_q);
  assign sts_o.sum_zero = (sum_q == '0);
  assign sts_o.out_free = !out_valid_q || !out_stall_i;

  // table: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mem[entry_index_i] <= fitness_value_i;
    end
    if (rd_en) begin
      rd_data_q <= mem[addr_q];
    end
  end

  // arithmetic payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      frac_q <= random_fraction_i;
      sum_q  <= '0;
    end
    if (rd_en) begin
      rd_idx_q  <= addr_q;
      rd_last_q <= (addr_q == n_m1);
    end
    if (cmd_i.sum_run && rdv_q) begin
      sum_q <= sum_q + SUM_BITS'(rd_data_q);
    end
    if (cmd_i.mul_lo) begin
      prod_lo_q <= frac_q * sum_q[FRAC_BITS-1:0];
      zero_q    <= (sum_q == '0);
    end
    if (cmd_i.mul_hi) begin
      // top bits of fraction x total: a pick hits once cum exceeds them
      thresh_q <= SUM_BITS'(prod_lo_q[2*FRAC_BITS-1:FRAC_BITS]) + part_hi;
      cum_q    <= '0;
    end
    if (cmd_i.scan_run && rdv_q) begin
      cum_q <= cum_d;
      if (sts_o.hit || rd_last_q) begin
        pick_q <= rd_idx_q;
      end
    end
    if (cmd_i.emit) begin
      if (zero_q) begin
        sel_q      <= '0;
        mother_q   <= awaiting_q;
        done_q     <= 1'b0;
        zero_out_q <= 1'b1;
      end else begin
        sel_q      <= pick_q;
        mother_q   <= awaiting_q;
        done_q     <= awaiting_q && mother_done;
        zero_out_q <= 1'b0;
      end
    end
  end

  // control and pair state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pop_q        <= POP_BITS'(POP_RESET);
      addr_q       <= '0;
      issue_done_q <= 1'b0;
      rdv_q        <= 1'b0;
      awaiting_q   <= 1'b0;
      father_q     <= '0;
      draws_q      <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        pop_q <= population_size_i;
      end
      rdv_q <= rd_en;
      if (cmd_i.start || cmd_i.mul_hi) begin
        addr_q       <= '0;
        issue_done_q <= 1'b0;
      end else if (rd_en) begin
        addr_q       <= addr_q + IDX_BITS'(1);
        issue_done_q <= (addr_q == n_m1);
      end
      if (cmd_i.emit && !zero_q) begin
        if (!awaiting_q) begin
          father_q   <= pick_q;
          awaiting_q <= 1'b1;
          draws_q    <= '0;
        end else if (mother_done) begin
          awaiting_q <= 1'b0;
          draws_q    <= '0;
        end else begin
          draws_q <= draws_inc;
        end
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o      = out_valid_q;
  assign selected_index_o = sel_q;
  assign is_mother_o      = mother_q;
  assign pair_done_o      = done_q;
  assign zero_total_o     = zero_out_q;

endmodule

[src/fpps_chk.sv]
// ----------------------------------------------------------------------------
// fpps_chk
// Port-level checks for the parent selector, bound to the top level.
// ----------------------------------------------------------------------------
module fpps_chk (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_stall_o,
  input logic                         req_type_i,
  input logic                         out_valid_o,
  input logic                         out_stall_i,
  input logic [fpps_pkg::IDX_BITS-1:0]  selected_index_o,
  input logic                         is_mother_o,
  input logic                         pair_done_o,
  input logic                         zero_total_o
);
  import fpps_pkg::*;

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(selected_index_o)
      && $stable(pair_done_o) && $stable(is_mother_o))
    else $error("stalled result changed");

  // a draw keeps the input busy in the next cycle
  a_draw_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (req_type_i == REQ_DRAW) |=> in_stall_o)
    else $error("draw did not occupy the block");

  // zero-total result carries no pick and no pair completion
  a_zero_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && zero_total_o |-> !pair_done_o && (selected_index_o == '0))
    else $error("zero-total result malformed");

  // only a mother candidate completes a pair
  a_done_mother: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && pair_done_o |-> is_mother_o)
    else $error("pair completed by a father pick");

endmodule

bind fitness_proportionate_parent_select fpps_chk u_fpps_chk (.*);

[bench/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the roulette-wheel parent selector. A local
// predictor mirrors the fitness table, the population register and the
// father/mother pair state. It computes the pick for every accepted draw.
// A sink process compares each result transfer against the oldest pick
// still waiting. The stimulus starts with directed cases and then runs
// randomised phases. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module testbench;
  import fpps_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int LOAD_SETTLE = 8;
  localparam int DRAW_SETTLE = 140;
  localparam int PHASES      = 10;
  localparam int PHASE_ITEMS = 40;

  // one result transfer as the predictor sees it
  typedef struct packed {
    logic [IDX_BITS-1:0] idx;
    logic                mother;
    logic                done;
    logic                zero;
  } pick_t;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  logic                 req_type;
  logic [IDX_BITS-1:0]  entry_index;
  logic [FIT_BITS-1:0]  fitness_value;
  logic [FRAC_BITS-1:0] random_fraction;
  logic                 out_valid;
  logic                 out_stall;
  logic [IDX_BITS-1:0]  selected_index;
  logic                 is_mother;
  logic                 pair_done;
  logic                 zero_total;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [POP_BITS-1:0]  pop_size;

  // predictor state
  logic [FIT_BITS-1:0]  fit_tbl [POP_MAX];
  logic [POP_BITS-1:0]  pop_reg;
  logic                 want_mother;
  logic [IDX_BITS-1:0]  father;
  logic [DRAW_BITS-1:0] mother_cnt;

  pick_t expected_picks[$];
  int    errors = 0;
  int    cycle_count = 0;
  bit    quiet = 1'b0;   // when set, neither side idles nor stalls

  fitness_proportionate_parent_select dut (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .in_valid_i        (in_valid),
    .in_stall_o        (in_stall),
    .req_type_i        (req_type),
    .entry_index_i     (entry_index),
    .fitness_value_i   (fitness_value),
    .random_fraction_i (random_fraction),
    .out_valid_o       (out_valid),
    .out_stall_i       (out_stall),
    .selected_index_o  (selected_index),
    .is_mother_o       (is_mother),
    .pair_done_o       (pair_done),
    .zero_total_o      (zero_total),
    .cfg_valid_i       (cfg_valid),
    .cfg_ready_o       (cfg_ready),
    .population_size_i (pop_size)
  );

  always #5 clk = ~clk;

  // watchdog: a hung handshake ends the run here
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // population register as the block uses it: clamped to [2, POP_MAX]
  function automatic int clamp_pop(input logic [POP_BITS-1:0] v);
    if (v < 2) return 2;
    if (v > POP_MAX) return POP_MAX;
    return v;
  endfunction

  // Roulette pick without division: first k with frac * S < C(k+1) * 2^32.
  // Widths are wide enough for 64 full-scale entries times a 32-bit fraction.
  function automatic void predict_draw(input logic [FRAC_BITS-1:0] frac);
    int                            n;
    int                            k;
    logic [SUM_BITS-1:0]           total;
    logic [SUM_BITS-1:0]           cum;
    logic [FRAC_BITS+SUM_BITS-1:0] frac_w;
    logic [FRAC_BITS+SUM_BITS-1:0] total_w;
    logic [FRAC_BITS+SUM_BITS-1:0] scaled;
    logic [FRAC_BITS+SUM_BITS-1:0] bar;
    logic [IDX_BITS-1:0]           pick;
    bit                            hit;
    pick_t                         r;
    n = clamp_pop(pop_reg);
    total = '0;
    for (k = 0; k < n; k++) total = total + fit_tbl[k];
    r = '0;
    if (total == 0) begin
      // error flag only; pair state is left alone
      r.zero   = 1'b1;
      r.mother = want_mother;
      expected_picks.push_back(r);
      return;
    end
    frac_w  = frac;
    total_w = total;
    scaled  = frac_w * total_w;
    pick    = IDX_BITS'(n - 1);
    cum     = '0;
    hit     = 1'b0;
    for (k = 0; k < n; k++) begin
      cum = cum + fit_tbl[k];
      bar = {cum, {FRAC_BITS{1'b0}}};
      if (!hit && scaled < bar) begin
        pick = IDX_BITS'(k);
        hit  = 1'b1;
      end
    end
    r.idx = pick;
    if (!want_mother) begin
      father      = pick;
      want_mother = 1'b1;
      mother_cnt  = '0;
    end else begin
      // retry while the candidate repeats the father, up to the draw limit
      mother_cnt = mother_cnt + 1'b1;
      r.mother   = 1'b1;
      r.done     = (pick != father) || (mother_cnt >= MAX_MOTHER_DRAWS);
      if (r.done) begin
        want_mother = 1'b0;
        mother_cnt  = '0;
      end
    end
    expected_picks.push_back(r);
  endfunction

  // One input transfer. Entered and left in the time step of a rising edge.
  // Valid is left high so that a following item can go back to back; any
  // pause lowers it first.
  task automatic send_item(input logic kind, input logic [IDX_BITS-1:0] idx,
                           input logic [FIT_BITS-1:0] fit,
                           input logic [FRAC_BITS-1:0] frac);
    int gap;
    bit taken;
    gap = quiet ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    req_type        <= kind;
    entry_index     <= idx;
    fitness_value   <= fit;
    random_fraction <= frac;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end
    if (kind == REQ_LOAD) fit_tbl[idx] = fit;
    else predict_draw(frac);
  endtask

  task automatic load_entry(input int idx, input logic [FIT_BITS-1:0] fit);
    send_item(REQ_LOAD, IDX_BITS'(idx), fit, $urandom);
  endtask

  task automatic draw(input logic [FRAC_BITS-1:0] frac);
    send_item(REQ_DRAW, IDX_BITS'($urandom), $urandom, frac);
  endtask

  // stop sending, let every expected result arrive, then let the block settle
  task automatic wait_drain(input int settle);
    in_valid <= 1'b0;
    while (expected_picks.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic set_population(input logic [POP_BITS-1:0] v);
    bit taken;
    wait_drain(LOAD_SETTLE);
    cfg_valid <= 1'b1;
    pop_size  <= v;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = cfg_ready;
      @(posedge clk);
    end
    cfg_valid <= 1'b0;
    pop_reg = v;
  endtask

  function automatic logic [FIT_BITS-1:0] fitness_for(input int style, input int idx,
                                                      input int heavy);
    case (style)
      0:       return $urandom;
      1:       return $urandom_range(0, 15);
      2:       return ($urandom_range(0, 7) == 0) ? $urandom : 0;
      default: return (idx == heavy) ? ($urandom | 1) : 0;
    endcase
  endfunction

  function automatic logic [FRAC_BITS-1:0] fraction_pick();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return $urandom_range(0, 255);
      default: return $urandom;
    endcase
  endfunction

  task automatic check_field(input string name, input logic [IDX_BITS-1:0] want,
                             input logic [IDX_BITS-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
      errors++;
    end
  endtask

  // Result sink: random stall before each transfer, then compare with the
  // oldest prediction. Sampled at the falling edge, where all is settled.
  initial begin : result_sink
    int    hold;
    bit    took;
    pick_t seen;
    pick_t want;
    @(posedge rst_n);
    forever begin
      hold = quiet ? 0 : $urandom_range(0, 6);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
        out_stall <= 1'b0;
      end
      took = 1'b0;
      while (!took) begin
        @(negedge clk);
        took = out_valid && !out_stall;
        if (took) begin
          seen.idx    = selected_index;
          seen.mother = is_mother;
          seen.done   = pair_done;
          seen.zero   = zero_total;
        end
        @(posedge clk);
      end
      if (expected_picks.size() == 0) begin
        $display("%0t: result with none expected, actual idx %0d mother %0b done %0b zero %0b",
                 $time, seen.idx, seen.mother, seen.done, seen.zero);
        errors++;
      end else begin
        want = expected_picks.pop_front();
        check_field("selected_index", want.idx, seen.idx);
        check_field("is_mother", want.mother, seen.mother);
        check_field("pair_done", want.done, seen.done);
        check_field("zero_total", want.zero, seen.zero);
      end
    end
  end

  // ---------------------------------------------------------------- tests

  // all-zero table: error flag in the father phase, pair state untouched
  task automatic test_zero_total();
    int k;
    for (k = 0; k < POP_MAX; k++) load_entry(k, '0);
    draw('1);
    draw($urandom);
  endtask

  // full-scale fitness everywhere; reset population of 64 shows in index 63
  task automatic test_full_scale();
    int k;
    for (k = 0; k < POP_MAX; k++) load_entry(k, '1);
    draw('0);
    draw('1);
    draw(32'h8000_0000);
    draw(32'h0000_0001);
  endtask

  // zero-weight slots must never be picked, even at fraction zero
  task automatic test_zero_weight_skip();
    int k;
    for (k = 0; k < POP_MAX; k++)
      load_entry(k, (k == 4 || k == 9 || k == 40) ? $urandom | 32'h1 : 32'h0);
    draw('0);
    draw('1);
    draw($urandom);
    draw($urandom);
  endtask

  task automatic probe_population(input logic [POP_BITS-1:0] v);
    set_population(v);
    draw('1);
    draw($urandom);
  endtask

  // out-of-range register values clamp to 2 and to POP_MAX
  task automatic test_population_clamp();
    int k;
    for (k = 0; k < POP_MAX; k++) load_entry(k, $urandom);
    probe_population(0);
    probe_population(1);
    probe_population(2);
    probe_population(127);
    probe_population(65);
    probe_population(64);
  endtask

  // Single live entry: father 63, a zero total in the mother phase, then
  // mother retries run out and the repeat is accepted on the last draw.
  task automatic test_mother_limit();
    int k;
    for (k = 0; k < POP_MAX - 1; k++) load_entry(k, '0);
    load_entry(POP_MAX - 1, '1);
    draw($urandom);
    set_population(2);
    draw($urandom);
    set_population(64);
    repeat (MAX_MOTHER_DRAWS) draw(fraction_pick());
  endtask

  // Randomised phases: each sets a population, reshapes the table (all but
  // style 0) and then mixes loads and draws. Some phases run flat out, some
  // pause mid-way until every result has come back.
  task automatic test_random_phases();
    int                  phase;
    int                  i;
    int                  k;
    int                  style;
    int                  heavy;
    logic [POP_BITS-1:0] pop;
    for (phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0:       pop = 2;
        1:       pop = 64;
        3:       pop = POP_BITS'($urandom_range(0, 1));
        4:       pop = POP_BITS'($urandom_range(65, 127));
        default: pop = POP_BITS'($urandom_range(2, 64));
      endcase
      style = phase % 4;
      heavy = $urandom_range(0, clamp_pop(pop) - 1);
      quiet = (phase % 5 == 2);
      set_population(pop);
      if (style != 0)
        for (k = 0; k < POP_MAX; k++) load_entry(k, fitness_for(style, k, heavy));
      for (i = 0; i < PHASE_ITEMS; i++) begin
        if (i == PHASE_ITEMS / 2 && phase % 2 == 1) wait_drain(LOAD_SETTLE);
        if ($urandom_range(0, 3) == 0) begin
          k = $urandom_range(0, POP_MAX - 1);
          load_entry(k, fitness_for(style, k, heavy));
        end else begin
          draw(fraction_pick());
        end
      end
    end
    quiet = 1'b0;
  endtask

  initial begin
    rst_n           <= 1'b0;
    in_valid        <= 1'b0;
    req_type        <= REQ_LOAD;
    entry_index     <= '0;
    fitness_value   <= '0;
    random_fraction <= '0;
    out_stall       <= 1'b0;
    cfg_valid       <= 1'b0;
    pop_size        <= POP_RESET;
    pop_reg     = POP_RESET;
    want_mother = 1'b0;
    father      = '0;
    mother_cnt  = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_zero_total();
    test_full_scale();
    test_zero_weight_skip();
    test_population_clamp();
    test_mother_limit();
    test_random_phases();

    // anything still waiting, or a stray result in the settle window, fails
    wait_drain(DRAW_SETTLE);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
